### sv/delimited_decimal_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the delimited decimal frame parser
// Shared concurrent-assertion shorthands, clocked on clock, reset by reset.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_DECIMAL_FRAME_PARSER_TOP_MACROS_SVH
`define DELIMITED_DECIMAL_FRAME_PARSER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DDFP_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ddfp assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DDFP_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ddfp assertion failed");

`endif

### sv/ddfp_pkg.sv
// ----------------------------------------------------------------------------
// ddfp_pkg
// Constants and shared types of the delimited decimal frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package ddfp_pkg;

   localparam int NUM_FIELDS = 4;
   localparam int DIGITS     = 3;

   localparam int BYTE_W      = 8;
   localparam int VAL_W       = 16;
   localparam int IDX_W       = 4;
   localparam int REQ_TDATA_W = 8;
   localparam int RSP_TDATA_W = 24;

   // field counter runs 0..NUM_FIELDS, digit counter 0..DIGITS
   localparam int FIDX_W = $clog2(NUM_FIELDS + 1);
   localparam int DCNT_W = $clog2(DIGITS + 1);
   localparam int ADDR_W = (NUM_FIELDS > 1) ? $clog2(NUM_FIELDS) : 1;

   localparam logic [BYTE_W-1:0] CH_START = 8'h23;
   localparam logic [BYTE_W-1:0] CH_END   = 8'h24;
   localparam logic [BYTE_W-1:0] CH_SEP   = 8'h2C;
   localparam logic [VAL_W-1:0]  CH_ZERO  = 16'h0030;

   typedef struct packed {
      logic is_start;
      logic is_end;
      logic is_sep;
      logic out_free;
   } ddfp_stat_type;

   typedef struct packed {
      logic              digit_we;
      logic              first_digit;
      logic [ADDR_W-1:0] wr_addr;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              load_out;
      logic              out_last;
   } ddfp_cmd_type;

endpackage

`default_nettype wire

### sv/ddfp_datapath.sv
// ----------------------------------------------------------------------------
// ddfp_datapath
// Byte decode, field accumulation, field store and result output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ddfp_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [ddfp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic                             csr_data,
   input  wire ddfp_pkg::ddfp_cmd_type           cmd,
   output ddfp_pkg::ddfp_stat_type               stat,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ddfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast
);
   import ddfp_pkg::*;

   logic              ascii_mode_ff;
   logic [VAL_W-1:0]  acc_ff;
   logic [VAL_W-1:0]  acc_in;
   logic [VAL_W-1:0]  acc_base;
   logic [VAL_W-1:0]  digit;
   logic [VAL_W-1:0]  acc_mem [NUM_FIELDS];
   logic [VAL_W-1:0]  rd_data_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [VAL_W-1:0]  rsp_value_ff;
   logic [IDX_W-1:0]  rsp_index_ff;
   logic              rsp_last_ff;

   assign csr_ready = 1'b1;

   assign stat.is_start = (req_tdata == CH_START);
   assign stat.is_end   = (req_tdata == CH_END);
   assign stat.is_sep   = (req_tdata == CH_SEP);
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   // digit: byte minus '0' wrapping to 16 bits, or the raw byte
   always_comb begin
      if (ascii_mode_ff) begin
         digit = {{(VAL_W-BYTE_W){1'b0}}, req_tdata} - CH_ZERO;
      end else begin
         digit = {{(VAL_W-BYTE_W){1'b0}}, req_tdata};
      end
      acc_base = cmd.first_digit ? '0 : acc_ff;
      acc_in   = (acc_base << 3) + (acc_base << 1) + digit;
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         ascii_mode_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            ascii_mode_ff <= csr_data;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.digit_we) begin
         acc_ff               <= acc_in;
         acc_mem[cmd.wr_addr] <= acc_in;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= acc_mem[cmd.rd_addr];
      end
      if (cmd.load_out) begin
         rsp_value_ff <= rd_data_ff;
         rsp_index_ff <= IDX_W'(cmd.rd_addr);
         rsp_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W-VAL_W-IDX_W){1'b0}}, rsp_index_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

### sv/ddfp_ctrl.sv
// ----------------------------------------------------------------------------
// ddfp_ctrl
// Frame state machine: digit and field counting, result read-out sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module ddfp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire ddfp_pkg::ddfp_stat_type stat,
   output ddfp_pkg::ddfp_cmd_type       cmd
);
   import ddfp_pkg::*;

   `include "delimited_decimal_frame_parser_top_macros.svh"

   typedef enum logic [1:0] {
      S_HUNT,
      S_FRAME,
      S_READ,
      S_LOAD
   } state_type;

   state_type         state_ff, state_in;
   logic [DCNT_W-1:0] fcnt_ff, fcnt_in;
   logic [FIDX_W-1:0] fidx_ff, fidx_in;
   logic [ADDR_W-1:0] ptr_ff, ptr_in;
   logic              accept;
   logic              frame_full;
   logic              field_full;
   logic              ptr_last;

   assign req_tready = (state_ff == S_HUNT) || (state_ff == S_FRAME);
   assign accept     = req_tvalid && req_tready;
   assign frame_full = (fidx_ff == FIDX_W'(NUM_FIELDS));
   assign field_full = (fcnt_ff == DCNT_W'(DIGITS));
   assign ptr_last   = (ptr_ff == ADDR_W'(NUM_FIELDS - 1));

   always_comb begin
      state_in = state_ff;
      fcnt_in  = fcnt_ff;
      fidx_in  = fidx_ff;
      ptr_in   = ptr_ff;

      cmd.digit_we    = 1'b0;
      cmd.first_digit = (fcnt_ff == '0);
      cmd.wr_addr     = fidx_ff[ADDR_W-1:0];
      cmd.rd_en       = 1'b0;
      cmd.rd_addr     = ptr_ff;
      cmd.load_out    = 1'b0;
      cmd.out_last    = ptr_last;

      unique case (state_ff)
         S_HUNT: begin
            if (accept && stat.is_start) begin
               state_in = S_FRAME;
               fcnt_in  = '0;
               fidx_in  = '0;
            end
         end
         S_FRAME: begin
            if (accept) begin
               if (stat.is_end) begin
                  fcnt_in  = '0;
                  fidx_in  = '0;
                  ptr_in   = '0;
                  state_in = frame_full ? S_READ : S_HUNT;
               end else if (stat.is_sep) begin
                  if (field_full) begin
                     fcnt_in = '0;
                  end else begin
                     state_in = S_HUNT;
                  end
               end else if (field_full || frame_full) begin
                  // drop: digit beyond field or frame length
                  state_in = S_HUNT;
               end else begin
                  cmd.digit_we = 1'b1;
                  fcnt_in      = DCNT_W'(fcnt_ff + 1'b1);
                  if (DCNT_W'(fcnt_ff + 1'b1) == DCNT_W'(DIGITS)) begin
                     fidx_in = FIDX_W'(fidx_ff + 1'b1);
                  end
               end
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_LOAD;
         end
         S_LOAD: begin
            if (stat.out_free) begin
               cmd.load_out = 1'b1;
               if (ptr_last) begin
                  state_in = S_HUNT;
               end else begin
                  ptr_in   = ADDR_W'(ptr_ff + 1'b1);
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HUNT;
         fcnt_ff  <= '0;
         fidx_ff  <= '0;
         ptr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         fcnt_ff  <= fcnt_in;
         fidx_ff  <= fidx_in;
         ptr_ff   <= ptr_in;
      end
   end

   `DDFP_ASSERT_SAME(a_counts_bounded, 1'b1,
                     (fcnt_ff <= DCNT_W'(DIGITS)) && (fidx_ff <= FIDX_W'(NUM_FIELDS)))
   `DDFP_ASSERT_NEXT(a_readout_starts_at_zero,
                     (state_ff == S_FRAME) && (state_in == S_READ), ptr_ff == '0)
   `DDFP_ASSERT_SAME(a_readout_needs_full_frame,
                     (state_ff == S_FRAME) && (state_in == S_READ), frame_full && accept)
   `DDFP_ASSERT_NEXT(a_load_after_read, state_ff == S_READ, state_ff == S_LOAD)
   `DDFP_ASSERT_SAME(a_no_intake_in_readout,
                     (state_ff == S_READ) || (state_ff == S_LOAD), !req_tready)

endmodule

`default_nettype wire

### sv/delimited_decimal_frame_parser_top.sv
// ----------------------------------------------------------------------------
// delimited_decimal_frame_parser_top
// Parses '#' f0 ',' f1 ... '$' frames of fixed-width decimal fields.
// ----------------------------------------------------------------------------
// Feed one received byte per req item. While parsing, a byte is taken every
// cycle. A closing '$' on a frame with exactly NUM_FIELDS x DIGITS digits
// emits NUM_FIELDS rsp items (value, index, tlast on the final field); during
// that read-out req_tready stays low while each field is first read from the
// field store and then loaded into the output register, for all NUM_FIELDS
// fields (four by default), and while rsp back-pressure holds a load. The last
// result may still wait in the output register while new bytes are taken.
// Malformed frames (short field before ',', extra digit, short total before
// '$') are dropped silently and the parser hunts for the next '#'. A '#'
// inside a frame counts as a digit byte. csr_data sets ascii_mode (reset 1):
// 1 takes digit = byte - '0', 0 takes the raw byte; write it only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module delimited_decimal_frame_parser_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // req_tdata: [7:0] rx_byte
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [ddfp_pkg::REQ_TDATA_W-1:0] req_tdata,
   // rsp_tdata: [15:0] field_value, [19:16] field_index, [23:20] zero
   // rsp_tlast: last_field
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [ddfp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,
   // csr_data: ascii_mode
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic                             csr_data
);
   import ddfp_pkg::*;

   ddfp_cmd_type  cmd;
   ddfp_stat_type stat;

   // control: frame tracking and read-out sequencing
   ddfp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath: decode, accumulate, store fields, hold the result
   ddfp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire
